FILE: rtl/core/frt_pkg.sv
// ----------------------------------------------------------------------------
// frt_pkg
// Shared types and constants of the fragment reassembly tracker: request and
// response words, status codes, register indexes and the map update group.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package frt_pkg;

   // configuration port geometry
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 25;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BYTES = 8'd1;

   // register reset values
   localparam logic [7:0]  TIMEOUT_RESET   = 8'd10;
   localparam logic [24:0] MAX_BYTES_RESET = 25'd10485760;

   // fragment stride is 8192 bytes, so the offset is the sequence shifted by 13
   localparam int STRIDE_SHIFT = 13;
   // sequence bits that can reach the offset (largest map is 4096 entries)
   localparam int SEQ_OFF_W    = 12;

   // received map is kept as rows of this many bits
   localparam int ROW_W     = 32;
   localparam int ROW_BIT_W = 5;

   typedef enum logic [2:0] {
      ST_STORED    = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_REJECTED  = 3'd2,
      ST_TIMEOUT   = 3'd3,
      ST_NO_ACTION = 3'd4
   } status_type;

   typedef struct packed {
      logic        mode;
      logic [31:0] image_tag;
      logic [31:0] seq_num;
      logic [31:0] frag_count;
      logic [15:0] frag_bytes;
      logic        is_last_frag;
   } req_word_type;

   typedef struct packed {
      status_type  status;
      logic [23:0] write_offset;
      logic [15:0] write_length;
      logic        new_image;
      logic        previous_dropped;
      logic        image_complete;
      logic [24:0] image_size;
   } rsp_word_type;

   // map update for the item leaving the input stage
   typedef struct packed {
      logic clear;   // a new image starts: forget every row
      logic mark;    // set the bit of the current sequence number
   } map_upd_type;

endpackage

FILE: rtl/core/fragment_reassembly_tracker.sv
// A word accepted on req passes the input stage (with the map read) and then
// the response register before it is offered on rsp. Throughput: one word per
// cycle while rsp_ready takes the responses; the map row read and its update
// overlap through a forwarded copy of the last row written.
// Reset: synchronous; no image in progress, registers back to their defaults,
// the received map empty at once through per-row valid flops (no sweep).
// ----------------------------------------------------------------------------
// fragment_reassembly_tracker
// Tracks one fragmented image from fragment headers and one-second ticks and
// classifies every fragment as stored, duplicate or rejected.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fragment_reassembly_tracker #(
   parameter int MAX_FRAGMENTS = 2048
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  frt_pkg::req_word_type              req_data,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output frt_pkg::rsp_word_type              rsp_data,
   // configuration
   input  logic                               csr_we,
   input  logic [frt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [frt_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int CNT_W = $clog2(MAX_FRAGMENTS + 1);

   // configuration registers
   logic [7:0]            timeout_ff;
   logic [24:0]           max_bytes_ff;

   // image state
   logic                  active_ff,   active_in;
   logic [31:0]           cur_id_ff,   cur_id_in;
   logic [31:0]           expect_ff,   expect_in;
   logic [CNT_W-1:0]      distinct_ff, distinct_in;
   logic [24:0]           final_ff,    final_in;
   logic [7:0]            idle_ff,     idle_in;

   // pipeline
   logic                  s1_valid_ff;
   frt_pkg::req_word_type s1_req_ff;
   logic                  rsp_valid_ff;
   frt_pkg::rsp_word_type rsp_ff, rsp_in;

   logic                  req_fire;
   logic                  s1_fire;
   logic                  out_free;
   logic                  map_seen;
   frt_pkg::map_upd_type  map_upd;

   // per-item decode
   logic                  start_new;
   logic [31:0]           exp_eff;
   logic [CNT_W-1:0]      dist_eff;
   logic [CNT_W-1:0]      dist_next;
   logic [24:0]           fin_eff;
   logic                  seq_bad;
   logic [25:0]           off_sum;
   logic [24:0]           offset;
   logic [7:0]            idle_inc;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // received map
   frt_map #(
      .MAX_FRAGMENTS (MAX_FRAGMENTS)
   ) u_map (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_fire),
      .rd_seq  (req_data.seq_num),
      .cur_seq (s1_req_ff.seq_num),
      .upd     (map_upd),
      .seen    (map_seen)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= frt_pkg::TIMEOUT_RESET;
         max_bytes_ff <= frt_pkg::MAX_BYTES_RESET;
      end else if (csr_we) begin
         case (csr_index)
            frt_pkg::CSR_TIMEOUT:   timeout_ff   <= csr_wdata[7:0];
            frt_pkg::CSR_MAX_BYTES: max_bytes_ff <= csr_wdata[24:0];
            default: ;
         endcase
      end
   end

   // classify the word in the input stage and work out the next state
   always_comb begin
      start_new = !s1_req_ff.mode && (!active_ff || (s1_req_ff.image_tag != cur_id_ff));
      exp_eff   = start_new ? s1_req_ff.frag_count : expect_ff;
      dist_eff  = start_new ? '0 : distinct_ff;
      fin_eff   = start_new ? '0 : final_ff;
      dist_next = dist_eff + CNT_W'(1);
      seq_bad   = (s1_req_ff.seq_num >= exp_eff)
               || (s1_req_ff.seq_num >= 32'(MAX_FRAGMENTS));
      offset    = {s1_req_ff.seq_num[frt_pkg::SEQ_OFF_W-1:0],
                   {frt_pkg::STRIDE_SHIFT{1'b0}}};
      off_sum   = {1'b0, offset} + {10'd0, s1_req_ff.frag_bytes};
      idle_inc  = (idle_ff == 8'hFF) ? idle_ff : idle_ff + 8'd1;

      active_in   = active_ff;
      cur_id_in   = cur_id_ff;
      expect_in   = expect_ff;
      distinct_in = distinct_ff;
      final_in    = final_ff;
      idle_in     = idle_ff;
      map_upd     = '0;

      rsp_in                  = '0;
      rsp_in.status           = frt_pkg::ST_NO_ACTION;

      if (s1_req_ff.mode) begin
         // tick
         if (active_ff) begin
            idle_in = idle_inc;
            if (idle_inc > timeout_ff) begin
               active_in     = 1'b0;
               rsp_in.status = frt_pkg::ST_TIMEOUT;
            end
         end
      end else begin
         // fragment header
         rsp_in.new_image        = start_new;
         rsp_in.previous_dropped = start_new && active_ff;
         map_upd.clear           = start_new;
         active_in               = 1'b1;
         cur_id_in               = s1_req_ff.image_tag;
         expect_in               = exp_eff;
         distinct_in             = dist_eff;
         final_in                = fin_eff;
         idle_in                 = 8'd0;

         if (seq_bad) begin
            rsp_in.status = frt_pkg::ST_REJECTED;
         end else if (!start_new && map_seen) begin
            rsp_in.status = frt_pkg::ST_DUPLICATE;
         end else if (off_sum > {1'b0, max_bytes_ff}) begin
            rsp_in.status = frt_pkg::ST_REJECTED;
         end else begin
            rsp_in.status       = frt_pkg::ST_STORED;
            rsp_in.write_offset = offset[23:0];
            rsp_in.write_length = s1_req_ff.frag_bytes;
            map_upd.mark        = 1'b1;
            distinct_in         = dist_next;
            if (s1_req_ff.is_last_frag) begin
               final_in = off_sum[24:0];
            end
            if (32'(dist_next) == exp_eff) begin
               rsp_in.image_complete = 1'b1;
               rsp_in.image_size     = final_in;
               active_in             = 1'b0;
            end
         end
      end

      // nothing moves unless the word leaves the input stage
      if (!s1_fire) begin
         map_upd = '0;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         active_ff    <= 1'b0;
         cur_id_ff    <= '0;
         expect_ff    <= '0;
         distinct_ff  <= '0;
         final_ff     <= '0;
         idle_ff      <= '0;
      end else begin
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (s1_fire) begin
            active_ff   <= active_in;
            cur_id_ff   <= cur_id_in;
            expect_ff   <= expect_in;
            distinct_ff <= distinct_in;
            final_ff    <= final_in;
            idle_ff     <= idle_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_req_ff <= req_data;
      end
      if (s1_fire) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

FILE: rtl/core/frt_ram.sv
// ----------------------------------------------------------------------------
// frt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic                                     re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/core/frt_map.sv
// ----------------------------------------------------------------------------
// frt_map
// Received-fragment map: one bit per sequence number, stored as RAM rows
// with a valid flop per row so that a new image clears the map at once.
// The last row written is forwarded to cover read-during-write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frt_map #(
   parameter int MAX_FRAGMENTS = 2048
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_en,
   input  logic [31:0]         rd_seq,
   input  logic [31:0]         cur_seq,
   input  frt_pkg::map_upd_type upd,
   output logic                seen
);

   localparam int MAP_ROWS = (MAX_FRAGMENTS + frt_pkg::ROW_W - 1) / frt_pkg::ROW_W;
   localparam int ROW_AW   = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
   localparam int PIDX_W   = ROW_AW + frt_pkg::ROW_BIT_W;

   logic [MAP_ROWS-1:0]             row_valid_ff;
   logic [MAP_ROWS-1:0]             row_valid_in;
   logic                            fwd_valid_ff;
   logic [ROW_AW-1:0]               fwd_row_ff;
   logic [frt_pkg::ROW_W-1:0]       fwd_data_ff;

   logic [ROW_AW-1:0]               rd_row;
   logic [ROW_AW-1:0]               cur_row;
   logic [frt_pkg::ROW_BIT_W-1:0]   cur_bit;
   logic [frt_pkg::ROW_W-1:0]       ram_rdata;
   logic [frt_pkg::ROW_W-1:0]       row_data;
   logic [frt_pkg::ROW_W-1:0]       row_eff;
   logic [frt_pkg::ROW_W-1:0]       wr_data;

   assign rd_row  = rd_seq[PIDX_W-1:frt_pkg::ROW_BIT_W];
   assign cur_row = cur_seq[PIDX_W-1:frt_pkg::ROW_BIT_W];
   assign cur_bit = cur_seq[frt_pkg::ROW_BIT_W-1:0];

   frt_ram #(
      .WIDTH (frt_pkg::ROW_W),
      .DEPTH (MAP_ROWS)
   ) u_ram (
      .clock (clock),
      .we    (upd.mark),
      .waddr (cur_row),
      .wdata (wr_data),
      .re    (rd_en),
      .raddr (rd_row),
      .rdata (ram_rdata)
   );

   // current row: forwarded copy wins, stale rows read as empty
   always_comb begin
      row_data = (fwd_valid_ff && (fwd_row_ff == cur_row)) ? fwd_data_ff : ram_rdata;
      row_eff  = row_valid_ff[cur_row] ? row_data : '0;
      seen     = row_eff[cur_bit];
      wr_data  = (upd.clear ? '0 : row_eff) | (frt_pkg::ROW_W'(1) << cur_bit);
   end

   // row valid bits: clear on new image, set on mark
   always_comb begin
      row_valid_in = upd.clear ? '0 : row_valid_ff;
      if (upd.mark) begin
         row_valid_in[cur_row] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         row_valid_ff <= row_valid_in;
         if (upd.mark) begin
            fwd_valid_ff <= 1'b1;
         end
      end
   end

   // forwarding payload
   always_ff @(posedge clock) begin
      if (upd.mark) begin
         fwd_row_ff  <= cur_row;
         fwd_data_ff <= wr_data;
      end
   end

endmodule

FILE: rtl/core/frt_checker.sv
// ----------------------------------------------------------------------------
// frt_checker
// Port-level checks of the fragment reassembly tracker, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frt_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input frt_pkg::rsp_word_type          rsp_data
);

   // no word comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // completion only comes with a stored fragment
   a_complete_stored: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.image_complete |-> rsp_data.status == frt_pkg::ST_STORED)
      else $error("completion without a stored fragment");

   // a word that reports a dropped image always starts a new one
   a_drop_new: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.previous_dropped |-> rsp_data.new_image)
      else $error("image dropped without a new image");

   // only stored fragments carry a write window
   a_window_stored: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != frt_pkg::ST_STORED
      |-> rsp_data.write_length == 16'd0 && rsp_data.write_offset == 24'd0
          && rsp_data.image_size == 25'd0)
      else $error("write window on a word that was not stored");

endmodule

bind fragment_reassembly_tracker frt_checker u_frt_checker (.*);

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the fragment reassembly tracker. A directed table
// covers field extremes, timeouts, range rejects and register corners. Random
// bursts of fragments with ticks and noise follow under three idle patterns.
// Every response word is compared against a typed table entry or an in-bench tracker model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   localparam int MAX_FRAGS   = 2048;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_WAIT  = 4;
   // an index past the last register, writes there must be dropped
   localparam logic [frt_pkg::CSR_IDX_W-1:0] CSR_UNUSED = frt_pkg::CSR_MAX_BYTES + 8'd1;

   typedef struct {
      bit                             is_reg;
      logic [frt_pkg::CSR_IDX_W-1:0]  reg_idx;
      logic [frt_pkg::CSR_DATA_W-1:0] reg_val;
      frt_pkg::req_word_type          word;
      bit                             typed;
      frt_pkg::rsp_word_type          typed_rsp;
   } step_row_type;

   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   frt_pkg::req_word_type          req_data  = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   frt_pkg::rsp_word_type          rsp_data;
   logic                           csr_we    = 1'b0;
   logic [frt_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [frt_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // tracker model state
   logic                  trk_active;
   logic [31:0]           trk_id;
   logic [31:0]           trk_expected;
   logic [MAX_FRAGS-1:0]  trk_map;
   logic [31:0]           trk_distinct;
   logic [24:0]           trk_final;
   logic [7:0]            trk_idle;
   logic [7:0]            trk_timeout;
   logic [24:0]           trk_max_bytes;

   frt_pkg::rsp_word_type due_rsp_q[$];
   step_row_type          dir_rows[$];
   int                    fail_count    = 0;
   int                    cycle_count   = 0;
   int                    send_idle_pct = 23;
   int                    rsp_idle_pct  = 65;
   int                    hold_left     = 0;
   bit                    hold_armed    = 1'b0;
   bit                    hold_done     = 1'b0;
   logic [31:0]           last_img      = '0;

   fragment_reassembly_tracker #(
      .MAX_FRAGMENTS(MAX_FRAGS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   // receiver: random stalls, plus one long hold-off once armed
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_armed && !hold_done) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   function automatic void note_failure(string what, frt_pkg::rsp_word_type exp,
                                        frt_pkg::rsp_word_type got);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%s: expected status=%0d off=%h len=%h new=%b drop=%b done=%b size=%h",
                  what, exp.status, exp.write_offset, exp.write_length, exp.new_image,
                  exp.previous_dropped, exp.image_complete, exp.image_size);
         $display("   got      status=%0d off=%h len=%h new=%b drop=%b done=%b size=%h",
                  got.status, got.write_offset, got.write_length, got.new_image,
                  got.previous_dropped, got.image_complete, got.image_size);
      end
   endfunction

   // response check against the oldest expected word
   always @(posedge clock) begin
      frt_pkg::rsp_word_type exp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_rsp_q.size() == 0) begin
            note_failure("unexpected response word", '0, rsp_data);
         end else begin
            exp = due_rsp_q.pop_front();
            if (rsp_data.status !== exp.status ||
                rsp_data.write_offset !== exp.write_offset ||
                rsp_data.write_length !== exp.write_length ||
                rsp_data.new_image !== exp.new_image ||
                rsp_data.previous_dropped !== exp.previous_dropped ||
                rsp_data.image_complete !== exp.image_complete ||
                rsp_data.image_size !== exp.image_size) begin
               note_failure("response mismatch", exp, rsp_data);
            end
         end
      end
   end

   // tracker model: classify one word and update the image state
   function automatic frt_pkg::rsp_word_type track_word(frt_pkg::req_word_type w);
      frt_pkg::rsp_word_type r;
      logic [63:0]           off;
      r = '0;
      r.status = frt_pkg::ST_NO_ACTION;
      if (w.mode) begin
         if (trk_active) begin
            if (trk_idle != 8'd255)
               trk_idle++;
            if (trk_idle > trk_timeout) begin
               trk_active = 1'b0;
               r.status = frt_pkg::ST_TIMEOUT;
            end
         end
      end else begin
         // new id or nothing in progress: start over
         if (!trk_active || w.image_tag != trk_id) begin
            r.previous_dropped = trk_active;
            r.new_image = 1'b1;
            trk_active = 1'b1;
            trk_id = w.image_tag;
            trk_expected = w.frag_count;
            trk_map = '0;
            trk_distinct = '0;
            trk_final = '0;
         end
         trk_idle = '0;
         off = {32'd0, w.seq_num} << 13;
         if (w.seq_num >= trk_expected || w.seq_num >= MAX_FRAGS) begin
            r.status = frt_pkg::ST_REJECTED;
         end else if (trk_map[w.seq_num]) begin
            r.status = frt_pkg::ST_DUPLICATE;
         end else if (off + w.frag_bytes > {39'd0, trk_max_bytes}) begin
            r.status = frt_pkg::ST_REJECTED;
         end else begin
            r.status = frt_pkg::ST_STORED;
            r.write_offset = off[23:0];
            r.write_length = w.frag_bytes;
            trk_map[w.seq_num] = 1'b1;
            trk_distinct++;
            if (w.is_last_frag)
               trk_final = off[24:0] + 25'(w.frag_bytes);
            if (trk_distinct == trk_expected) begin
               r.image_complete = 1'b1;
               r.image_size = trk_final;
               trk_active = 1'b0;
            end
         end
      end
      return r;
   endfunction

   function automatic frt_pkg::req_word_type frag_hdr(logic [31:0] id, logic [31:0] seq,
                                                      logic [31:0] total,
                                                      logic [15:0] size, logic last);
      frt_pkg::req_word_type w;
      w.mode = 1'b0;
      w.image_tag = id;
      w.seq_num = seq;
      w.frag_count = total;
      w.frag_bytes = size;
      w.is_last_frag = last;
      return w;
   endfunction

   // tick with junk in the ignored fields
   function automatic frt_pkg::req_word_type tick_word();
      frt_pkg::req_word_type w;
      w = frag_hdr($urandom, $urandom, $urandom, 16'($urandom), 1'($urandom));
      w.mode = 1'b1;
      return w;
   endfunction

   function automatic frt_pkg::rsp_word_type rsp_of(frt_pkg::status_type st,
                                                    logic [23:0] off, logic [15:0] len,
                                                    logic nw, logic dr, logic dn,
                                                    logic [24:0] sz);
      frt_pkg::rsp_word_type r;
      r.status = st;
      r.write_offset = off;
      r.write_length = len;
      r.new_image = nw;
      r.previous_dropped = dr;
      r.image_complete = dn;
      r.image_size = sz;
      return r;
   endfunction

   function automatic step_row_type word_row(frt_pkg::req_word_type w, bit typed,
                                             frt_pkg::rsp_word_type r);
      step_row_type row;
      row = '{default: '0};
      row.word = w;
      row.typed = typed;
      row.typed_rsp = r;
      return row;
   endfunction

   function automatic step_row_type reg_row(logic [frt_pkg::CSR_IDX_W-1:0] idx,
                                            logic [frt_pkg::CSR_DATA_W-1:0] val);
      step_row_type row;
      row = '{default: '0};
      row.is_reg = 1'b1;
      row.reg_idx = idx;
      row.reg_val = val;
      return row;
   endfunction

   // offer one word, wait for the handshake, then queue its expected response
   task automatic offer_word(frt_pkg::req_word_type w, bit typed,
                             frt_pkg::rsp_word_type typed_rsp);
      frt_pkg::rsp_word_type pred;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
      pred = track_word(w);
      due_rsp_q.push_back(typed ? typed_rsp : pred);
   endtask

   // stop offering and let every expected word come back
   task automatic settle_idle();
      req_valid <= 1'b0;
      while (due_rsp_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(logic [frt_pkg::CSR_IDX_W-1:0] idx,
                            logic [frt_pkg::CSR_DATA_W-1:0] val);
      settle_idle();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == frt_pkg::CSR_TIMEOUT)
         trk_timeout = val[7:0];
      else if (idx == frt_pkg::CSR_MAX_BYTES)
         trk_max_bytes = val;
   endtask

   // random traffic: mostly fragment bursts of one image, plus ticks and noise
   task automatic run_random_phase(int word_budget);
      int                    sent;
      int                    pick;
      int                    total;
      int                    span;
      int                    seqs[$];
      int                    j;
      int                    tmp;
      logic [31:0]           img;
      logic [31:0]           seq;
      logic [15:0]           size;
      frt_pkg::req_word_type w;
      sent = 0;
      while (sent < word_budget) begin
         pick = $urandom_range(99);
         if (pick < 72) begin
            img = ($urandom_range(3) == 0) ? last_img : $urandom;
            pick = $urandom_range(99);
            if (pick < 70)
               total = $urandom_range(1, 8);
            else if (pick < 92)
               total = $urandom_range(9, 40);
            else if (pick < 96)
               total = 0;
            else
               total = $urandom_range(2049, 100000);
            span = (total >= 1 && total <= 40) ? total : $urandom_range(1, 12);
            seqs.delete();
            for (int k = 0; k < span; k++)
               seqs.push_back((total >= 1 && total <= 40) ? k : $urandom_range(0, 2100));
            for (int k = span - 1; k > 0; k--) begin
               j = $urandom_range(k);
               tmp = seqs[k];
               seqs[k] = seqs[j];
               seqs[j] = tmp;
            end
            for (int k = 0; k < span; k++) begin
               if ($urandom_range(99) < 12) begin
                  offer_word(tick_word(), 1'b0, '0);
                  sent++;
               end
               seq = seqs[k];
               if ($urandom_range(99) < 6)
                  seq = ($urandom_range(1) == 0) ? total + $urandom_range(0, 3) : $urandom;
               pick = $urandom_range(9);
               size = (pick < 8) ? 16'($urandom_range(0, 8192)) :
                      (pick == 8) ? 16'hFFFF : 16'($urandom);
               w = frag_hdr(img, seq,
                            ($urandom_range(3) == 0) ? $urandom : total, size,
                            (seq == total - 1) ? ($urandom_range(9) != 0)
                                               : ($urandom_range(19) == 0));
               offer_word(w, 1'b0, '0);
               sent++;
               if ($urandom_range(99) < 8) begin
                  offer_word(w, 1'b0, '0);
                  sent++;
               end
               if ($urandom_range(99) < 4)
                  break;
            end
            last_img = img;
         end else if (pick < 90) begin
            repeat ($urandom_range(1, 15)) begin
               offer_word(tick_word(), 1'b0, '0);
               sent++;
            end
         end else begin
            w = tick_word();
            w.mode = 1'($urandom);
            if ($urandom_range(1) == 0)
               w.image_tag = last_img;
            if ($urandom_range(1) == 0)
               w.seq_num = $urandom_range(0, 40);
            offer_word(w, 1'b0, '0);
            sent++;
         end
      end
   endtask

   initial begin
      logic [31:0] id_a;
      logic [31:0] id_max;
      id_a = 32'h1234_5678;
      id_max = 32'hFFFF_FFFF;

      // model reset state
      trk_active = 1'b0;
      trk_id = '0;
      trk_expected = '0;
      trk_map = '0;
      trk_distinct = '0;
      trk_final = '0;
      trk_idle = '0;
      trk_timeout = frt_pkg::TIMEOUT_RESET;
      trk_max_bytes = frt_pkg::MAX_BYTES_RESET;

      // directed table
      dir_rows.push_back(word_row(tick_word(), 1'b1,
                                  rsp_of(frt_pkg::ST_NO_ACTION, 0, 0, 0, 0, 0, 0)));
      dir_rows.push_back(word_row(frag_hdr(id_a, 0, 3, 100, 0), 1'b1,
                                  rsp_of(frt_pkg::ST_STORED, 0, 100, 1, 0, 0, 0)));
      dir_rows.push_back(word_row(frag_hdr(id_a, 0, 3, 100, 0), 1'b1,
                                  rsp_of(frt_pkg::ST_DUPLICATE, 0, 0, 0, 0, 0, 0)));
      dir_rows.push_back(word_row(frag_hdr(id_a, 3, 3, 100, 0), 1'b1,
                                  rsp_of(frt_pkg::ST_REJECTED, 0, 0, 0, 0, 0, 0)));
      dir_rows.push_back(word_row(frag_hdr(id_a, 32'hFFFF_FFFF, 3, 16'hFFFF, 1), 1'b1,
                                  rsp_of(frt_pkg::ST_REJECTED, 0, 0, 0, 0, 0, 0)));
      dir_rows.push_back(word_row(frag_hdr(id_a, 2, 3, 16'hFFFF, 1), 1'b0, '0));
      dir_rows.push_back(word_row(frag_hdr(id_a, 1, 3, 0, 0), 1'b0, '0));
      dir_rows.push_back(word_row(tick_word(), 1'b1,
                                  rsp_of(frt_pkg::ST_NO_ACTION, 0, 0, 0, 0, 0, 0)));
      // zero fragment count: never completes
      dir_rows.push_back(word_row(frag_hdr(32'hA5A5_0001, 0, 0, 16, 0), 1'b0, '0));
      // one byte past the default byte limit, then exactly at it
      dir_rows.push_back(word_row(frag_hdr(32'd2, 1279, 2048, 8193, 0), 1'b1,
                                  rsp_of(frt_pkg::ST_REJECTED, 0, 0, 1, 1, 0, 0)));
      dir_rows.push_back(word_row(frag_hdr(32'd2, 1279, 2048, 8192, 0), 1'b0, '0));
      // short timeout: second idle tick abandons
      dir_rows.push_back(reg_row(frt_pkg::CSR_TIMEOUT, 1));
      dir_rows.push_back(word_row(tick_word(), 1'b0, '0));
      dir_rows.push_back(word_row(tick_word(), 1'b1,
                                  rsp_of(frt_pkg::ST_TIMEOUT, 0, 0, 0, 0, 0, 0)));
      dir_rows.push_back(word_row(tick_word(), 1'b1,
                                  rsp_of(frt_pkg::ST_NO_ACTION, 0, 0, 0, 0, 0, 0)));
      // byte limit of 2^24: top sequence fills it exactly
      dir_rows.push_back(reg_row(frt_pkg::CSR_MAX_BYTES, 25'h100_0000));
      dir_rows.push_back(word_row(frag_hdr(id_max, 2047, 2048, 8192, 1), 1'b0, '0));
      dir_rows.push_back(word_row(frag_hdr(id_max, 2048, 2048, 1, 0), 1'b1,
                                  rsp_of(frt_pkg::ST_REJECTED, 0, 0, 0, 0, 0, 0)));
      // zero byte limit: only empty fragment at offset zero fits
      dir_rows.push_back(reg_row(frt_pkg::CSR_MAX_BYTES, 0));
      dir_rows.push_back(word_row(frag_hdr(id_max, 0, 2048, 1, 0), 1'b1,
                                  rsp_of(frt_pkg::ST_REJECTED, 0, 0, 0, 0, 0, 0)));
      dir_rows.push_back(word_row(frag_hdr(id_max, 0, 2048, 0, 0), 1'b0, '0));
      dir_rows.push_back(word_row(frag_hdr(id_max, 0, 7, 0, 1), 1'b1,
                                  rsp_of(frt_pkg::ST_DUPLICATE, 0, 0, 0, 0, 0, 0)));
      dir_rows.push_back(word_row(frag_hdr(id_max, 5, 7, 0, 0), 1'b0, '0));
      dir_rows.push_back(reg_row(frt_pkg::CSR_TIMEOUT, 255));
      dir_rows.push_back(word_row(tick_word(), 1'b0, '0));
      dir_rows.push_back(reg_row(CSR_UNUSED, '1));
      dir_rows.push_back(reg_row(frt_pkg::CSR_MAX_BYTES, frt_pkg::MAX_BYTES_RESET));
      dir_rows.push_back(word_row(frag_hdr(32'd0, 0, 1, 16'hFFFF, 1), 1'b1,
                                  rsp_of(frt_pkg::ST_STORED, 0, 16'hFFFF, 1, 1, 1,
                                         25'hFFFF)));

      // reset
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_reg)
            write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
         else
            offer_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].typed_rsp);
      end

      // sender idles lightly, receiver heavily
      write_reg(frt_pkg::CSR_TIMEOUT, 3);
      write_reg(frt_pkg::CSR_MAX_BYTES, 200000);
      send_idle_pct = 23;
      rsp_idle_pct = 65;
      run_random_phase(400);

      // sender idles heavily, receiver lightly
      write_reg(frt_pkg::CSR_TIMEOUT, 0);
      write_reg(frt_pkg::CSR_MAX_BYTES, 25'h100_0000);
      send_idle_pct = 65;
      rsp_idle_pct = 23;
      run_random_phase(400);

      // no idling, long receiver hold-off, idle counter saturation
      write_reg(frt_pkg::CSR_TIMEOUT, 255);
      write_reg(frt_pkg::CSR_MAX_BYTES, frt_pkg::MAX_BYTES_RESET);
      send_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_armed = 1'b1;
      offer_word(frag_hdr($urandom, 0, 4, 1000, 0), 1'b0, '0);
      repeat (260)
         offer_word(tick_word(), 1'b0, '0);
      run_random_phase(340);

      settle_idle();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && due_rsp_q.size() == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
